[hw/rtl/rss_pkg.sv]
// Shared types and constants of the ranging and sampling sequencer.
// Holds the input, result and register-file words, control pin codes and
// register indexes; depends on nothing.
package rss_pkg;

    // Defaults of the top-level parameters
    localparam int SENSOR_COUNT_DEF = 4;
    localparam int SAMPLE_LIMIT_DEF = 1024;

    // Register file layout
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_TIME   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGING_TIME = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_MASK  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CAMERA       = 3'd5;

    localparam logic [23:0] CYCLE_TIME_RST   = 24'd500000;
    localparam logic [23:0] RANGING_TIME_RST = 24'd17000;
    localparam logic [23:0] WINDOW_RST       = 24'd33000;
    localparam logic [15:0] PERIOD_RST       = 16'd48;

    // Control pin codes: bit0 A2, bit1 A3, bit2 ALE
    localparam logic [2:0] CTL_ADDR    = 3'd4;
    localparam logic [2:0] CTL_RANGE   = 3'd1;
    localparam logic [2:0] CTL_CONVERT = 3'd2;
    localparam logic [2:0] CTL_LATCH   = 3'd3;

    typedef struct packed {
        logic [23:0] cycle_time_us;
        logic [23:0] ranging_time_us;
        logic [23:0] sampling_window_us;
        logic [15:0] sample_period_us;
        logic [3:0]  sensor_enable_mask;
        logic        camera_enable;
    } t_cfg;

    typedef struct packed {
        logic       start_request;
        logic [1:0] fire_sensor;
        logic       sample_all;
        logic       busy_pin;
        logic [7:0] data_bus;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  address_pins;
        logic [2:0]  control_pins;
        logic        camera_trigger;
        logic        active;
        logic        sample_valid;
        logic [1:0]  sample_sensor;
        logic [7:0]  sample_value;
        logic [31:0] sample_time;
        logic [9:0]  sample_index;
        logic        cycle_done;
        logic        start_rejected;
    } t_out_word;

    typedef enum logic [10:0] {
        PH_IDLE         = 11'b000_0000_0001,
        PH_WAIT_CYCLE   = 11'b000_0000_0010,
        PH_CONV_INIT    = 11'b000_0000_0100,
        PH_WAIT_RANGING = 11'b000_0000_1000,
        PH_CONV_FIRST   = 11'b000_0001_0000,
        PH_READ_BUSY    = 11'b000_0010_0000,
        PH_LATCH        = 11'b000_0100_0000,
        PH_CAPTURE      = 11'b000_1000_0000,
        PH_WAIT_PERIOD  = 11'b001_0000_0000,
        PH_CONV_NEXT    = 11'b010_0000_0000,
        PH_FINISH       = 11'b100_0000_0000
    } t_phase;

endpackage

[hw/rtl/ranging_sampling_sequencer_unit.sv]
// Top level of the ranging and sampling sequencer: register file, input
// and result handshakes, result register. Depends on rss_pkg and rss_seq.
//
// Usage:
//   Each input word is one microsecond tick carrying the start request,
//   the firing sensor, the all-sensors flag, the converter busy line and
//   the converter data byte. Every accepted word yields exactly one result
//   word with the address and control pin levels, camera trigger, active
//   and done flags, a possible start rejection and, on capture ticks, the
//   sample with its sensor, period timestamp and index.
//   The result of a word is in the result register in the cycle after
//   the word is accepted. Throughput: one word per cycle while the
//   receiver keeps taking results; the phase step is a single pass of
//   32-bit compares between the state registers and the result register.
//   Stall: when the receiver holds o_out_word, the input stays ready only
//   if the waiting result is taken in the same cycle; otherwise input
//   ready drops and the sequencer state holds.
//   Reset (i_rst_n low, synchronous): the phase goes idle, the counter,
//   timestamps and sample count clear and the registers return to their
//   defaults. Register writes through i_cfg_we are taken at once, any time.
module ranging_sampling_sequencer_unit
    import rss_pkg::*;
#(
    parameter int SENSOR_COUNT = SENSOR_COUNT_DEF,
    parameter int SAMPLE_LIMIT = SAMPLE_LIMIT_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_word              i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_word             o_out_word,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg      r_cfg;
    logic      r_out_valid;
    t_out_word r_out_word;
    t_out_word seq_res;
    logic      tick;

    // Take a new tick whenever the result slot is empty or being drained
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign tick        = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // Register file: write-only, truncate data to each register's width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cycle_time_us      <= CYCLE_TIME_RST;
            r_cfg.ranging_time_us    <= RANGING_TIME_RST;
            r_cfg.sampling_window_us <= WINDOW_RST;
            r_cfg.sample_period_us   <= PERIOD_RST;
            r_cfg.sensor_enable_mask <= '0;
            r_cfg.camera_enable      <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CYCLE_TIME:   r_cfg.cycle_time_us      <= i_cfg_data;
                CFG_RANGING_TIME: r_cfg.ranging_time_us    <= i_cfg_data;
                CFG_WINDOW:       r_cfg.sampling_window_us <= i_cfg_data;
                CFG_PERIOD:       r_cfg.sample_period_us   <= i_cfg_data[15:0];
                CFG_ENABLE_MASK:  r_cfg.sensor_enable_mask <= i_cfg_data[3:0];
                CFG_CAMERA:       r_cfg.camera_enable      <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    rss_seq #(
        .SENSOR_COUNT (SENSOR_COUNT),
        .SAMPLE_LIMIT (SAMPLE_LIMIT)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tick  (tick),
        .i_in    (i_in_word),
        .i_cfg   (r_cfg),
        .o_res   (seq_res)
    );

    // Result register: load on every accepted tick, hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (tick) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick) begin
            r_out_word <= seq_res;
        end
    end

endmodule

[hw/rtl/rss_seq.sv]
// Sequencer core: phase machine, microsecond counter, per-sensor ranging
// timestamps and a sample counter. Advances one step per accepted tick.
// Depends on rss_pkg.
module rss_seq
    import rss_pkg::*;
#(
    parameter int SENSOR_COUNT = SENSOR_COUNT_DEF,
    parameter int SAMPLE_LIMIT = SAMPLE_LIMIT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_tick,
    input  t_in_word  i_in,
    input  t_cfg      i_cfg,
    output t_out_word o_res
);

    localparam int IW = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
    localparam int CW = $clog2(SAMPLE_LIMIT + 1);
    localparam logic [IW-1:0] LAST_SENSOR = IW'(SENSOR_COUNT - 1);

    logic [31:0]   r_now;
    logic [31:0]   r_last [SENSOR_COUNT];
    t_phase        r_phase, n_phase;
    logic [31:0]   r_win, n_win;
    logic [31:0]   r_per, n_per;
    logic [CW-1:0] r_taken, n_taken;
    logic [IW-1:0] r_cursor, n_cursor;
    logic [IW-1:0] r_firing, n_firing;
    logic          r_all, n_all;

    logic          last_we;
    logic [IW-1:0] cur;
    logic          round_end;
    logic [IW-1:0] cursor_adv;
    logic          fire_ok;
    logic [31:0]   since_range;
    logic [31:0]   since_period;
    logic [31:0]   window_used;
    logic          window_over;

    assign cur         = r_all ? r_cursor : r_firing;
    assign round_end   = !(r_all && (r_cursor != LAST_SENSOR));
    assign cursor_adv  = round_end ? '0 : r_cursor + 1'b1;
    assign fire_ok     = ({1'b0, i_in.fire_sensor} < 3'(SENSOR_COUNT))
                         && i_cfg.sensor_enable_mask[i_in.fire_sensor];
    assign since_range  = r_now - r_last[r_firing];
    assign since_period = r_now - r_per;
    assign window_used  = r_per - r_win;
    assign window_over  = (r_taken >= CW'(SAMPLE_LIMIT))
                          || (window_used >= {8'd0, i_cfg.sampling_window_us});

    always_comb begin
        n_phase  = r_phase;
        n_win    = r_win;
        n_per    = r_per;
        n_taken  = r_taken;
        n_cursor = r_cursor;
        n_firing = r_firing;
        n_all    = r_all;
        last_we  = 1'b0;

        o_res                = '0;
        o_res.address_pins   = 2'(r_firing);
        o_res.control_pins   = CTL_ADDR;
        o_res.active         = (r_phase != PH_IDLE);
        o_res.start_rejected = (r_phase != PH_IDLE) && i_in.start_request;

        case (r_phase)
            PH_IDLE: begin
                if (i_in.start_request) begin
                    if (fire_ok) begin
                        n_firing           = IW'(i_in.fire_sensor);
                        n_all              = i_in.sample_all;
                        n_cursor           = '0;
                        n_taken            = '0;
                        n_phase            = PH_WAIT_CYCLE;
                        o_res.address_pins = i_in.fire_sensor;
                        o_res.active       = 1'b1;
                    end else begin
                        o_res.start_rejected = 1'b1;
                    end
                end
            end
            PH_WAIT_CYCLE: begin
                if (since_range >= {8'd0, i_cfg.cycle_time_us}) begin
                    last_we            = 1'b1;
                    o_res.control_pins = CTL_RANGE;
                    n_cursor           = '0;
                    n_phase            = PH_CONV_INIT;
                end
            end
            PH_CONV_INIT: begin
                o_res.address_pins = 2'(cur);
                o_res.control_pins = CTL_CONVERT;
                n_cursor           = cursor_adv;
                if (round_end) begin
                    o_res.camera_trigger = i_cfg.camera_enable;
                    n_phase              = PH_WAIT_RANGING;
                end
            end
            PH_WAIT_RANGING: begin
                if (since_range >= {8'd0, i_cfg.ranging_time_us}) begin
                    n_win   = r_now;
                    n_per   = r_now;
                    n_phase = PH_CONV_FIRST;
                end
            end
            PH_CONV_FIRST, PH_CONV_NEXT: begin
                o_res.address_pins = 2'(cur);
                o_res.control_pins = CTL_CONVERT;
                n_cursor           = cursor_adv;
                if (round_end) begin
                    n_phase = window_over ? PH_FINISH : PH_READ_BUSY;
                end
            end
            PH_READ_BUSY: begin
                o_res.address_pins = 2'(cur);
                if (!i_in.busy_pin) begin
                    n_phase = PH_LATCH;
                end
            end
            PH_LATCH: begin
                o_res.address_pins = 2'(cur);
                o_res.control_pins = CTL_LATCH;
                n_phase            = PH_CAPTURE;
            end
            PH_CAPTURE: begin
                o_res.address_pins  = 2'(cur);
                o_res.control_pins  = CTL_LATCH;
                o_res.sample_valid  = 1'b1;
                o_res.sample_sensor = 2'(cur);
                o_res.sample_value  = i_in.data_bus;
                o_res.sample_time   = r_per;
                o_res.sample_index  = 10'(r_taken);
                n_cursor            = cursor_adv;
                if (round_end) begin
                    n_taken = r_taken + 1'b1;
                    n_phase = PH_WAIT_PERIOD;
                end else begin
                    n_phase = PH_READ_BUSY;
                end
            end
            PH_WAIT_PERIOD: begin
                if (since_period >= {16'd0, i_cfg.sample_period_us}) begin
                    n_per   = r_now;
                    n_phase = PH_CONV_NEXT;
                end
            end
            PH_FINISH: begin
                o_res.cycle_done = 1'b1;
                n_phase          = PH_IDLE;
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now    <= '0;
            r_phase  <= PH_IDLE;
            r_win    <= '0;
            r_per    <= '0;
            r_taken  <= '0;
            r_cursor <= '0;
            r_firing <= '0;
            r_all    <= 1'b0;
            for (int k = 0; k < SENSOR_COUNT; k++) begin
                r_last[k] <= '0;
            end
        end else if (i_tick) begin
            r_now    <= r_now + 1'b1;
            r_phase  <= n_phase;
            r_win    <= n_win;
            r_per    <= n_per;
            r_taken  <= n_taken;
            r_cursor <= n_cursor;
            r_firing <= n_firing;
            r_all    <= n_all;
            if (last_we) begin
                r_last[r_firing] <= r_now;
            end
        end
    end

endmodule

[bench/ranging_sampling_sequencer_unit_tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for ranging_sampling_sequencer_unit: tick-accurate pin and sample
// predictor, bursty sender, stalling receiver, watchdog. Depends on rss_pkg and the unit.
module ranging_sampling_sequencer_unit_tb;
    import rss_pkg::*;

    localparam int SENSORS      = SENSOR_COUNT_DEF;
    localparam int ROUND_LIMIT  = SAMPLE_LIMIT_DEF;
    localparam int RANDOM_TICKS = 200;
    localparam int STALL_LIMIT  = 4000;
    localparam int MAX_REPORTS  = 40;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    t_in_word              i_in_word;
    logic                  o_out_valid;
    logic                  i_out_ready;
    t_out_word             o_out_word;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    ranging_sampling_sequencer_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_word (o_out_word),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // 8 ns clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Predictor copy of the register file
    logic [23:0] cfg_cycle_us;
    logic [23:0] cfg_ranging_us;
    logic [23:0] cfg_window_us;
    logic [15:0] cfg_period_us;
    logic [3:0]  cfg_enabled;
    logic        cfg_camera;

    // Predictor copy of the sequencer state
    logic [31:0] us_count;
    logic [31:0] last_fire [SENSORS];
    t_phase      seq_phase;
    logic [31:0] window_t0;
    logic [31:0] period_t0;
    logic [10:0] rounds_done;
    logic [1:0]  cursor;
    logic [1:0]  firing;
    logic        all_sensors;

    // Pin and sample words still owed by the unit, oldest first
    t_out_word pending_pins[$];

    int mismatch_count = 0;
    int quiet_cycles   = 0;
    int burst_left     = 0;
    int busy_hold      = 0;

    // Sensor being addressed within the current round
    function automatic logic [1:0] read_sensor();
        return all_sensors ? cursor : firing;
    endfunction

    // Step the round cursor; return one when the round is over
    function automatic logic round_done();
        if (all_sensors && int'(cursor) + 1 < SENSORS) begin
            cursor = cursor + 2'd1;
            return 1'b0;
        end
        cursor = 2'd0;
        return 1'b1;
    endfunction

    // Advance the sequencer by one microsecond tick and return the pins it drives
    function automatic t_out_word pins_for_tick(input t_in_word w);
        t_out_word   r;
        logic [31:0] now;
        logic [1:0]  s;
        now = us_count;
        r = '0;
        r.address_pins = firing;
        r.control_pins = CTL_ADDR;
        if (seq_phase != PH_IDLE) begin
            r.active = 1'b1;
            if (w.start_request) r.start_rejected = 1'b1;
        end
        case (seq_phase)
            PH_IDLE: begin
                if (w.start_request) begin
                    if (int'(w.fire_sensor) < SENSORS && cfg_enabled[w.fire_sensor]) begin
                        firing         = w.fire_sensor;
                        all_sensors    = w.sample_all;
                        cursor         = 2'd0;
                        rounds_done    = '0;
                        seq_phase      = PH_WAIT_CYCLE;
                        r.address_pins = w.fire_sensor;
                        r.active       = 1'b1;
                    end else begin
                        r.start_rejected = 1'b1;
                    end
                end
            end
            PH_WAIT_CYCLE: begin
                if (now - last_fire[firing] >= {8'd0, cfg_cycle_us}) begin
                    last_fire[firing] = now;
                    r.control_pins    = CTL_RANGE;
                    cursor            = 2'd0;
                    seq_phase         = PH_CONV_INIT;
                end
            end
            PH_CONV_INIT: begin
                r.address_pins = read_sensor();
                r.control_pins = CTL_CONVERT;
                if (round_done()) begin
                    r.camera_trigger = cfg_camera;
                    seq_phase        = PH_WAIT_RANGING;
                end
            end
            PH_WAIT_RANGING: begin
                if (now - last_fire[firing] >= {8'd0, cfg_ranging_us}) begin
                    window_t0 = now;
                    period_t0 = now;
                    seq_phase = PH_CONV_FIRST;
                end
            end
            PH_CONV_FIRST, PH_CONV_NEXT: begin
                r.address_pins = read_sensor();
                r.control_pins = CTL_CONVERT;
                if (round_done()) begin
                    // Window over or limit hit: finish without reading
                    if (int'(rounds_done) >= ROUND_LIMIT ||
                        period_t0 - window_t0 >= {8'd0, cfg_window_us})
                        seq_phase = PH_FINISH;
                    else
                        seq_phase = PH_READ_BUSY;
                end
            end
            PH_READ_BUSY: begin
                r.address_pins = read_sensor();
                if (!w.busy_pin) seq_phase = PH_LATCH;
            end
            PH_LATCH: begin
                r.address_pins = read_sensor();
                r.control_pins = CTL_LATCH;
                seq_phase      = PH_CAPTURE;
            end
            PH_CAPTURE: begin
                s               = read_sensor();
                r.address_pins  = s;
                r.control_pins  = CTL_LATCH;
                r.sample_valid  = 1'b1;
                r.sample_sensor = s;
                r.sample_value  = w.data_bus;
                r.sample_time   = period_t0;
                r.sample_index  = rounds_done[9:0];
                if (round_done()) begin
                    rounds_done = rounds_done + 11'd1;
                    seq_phase   = PH_WAIT_PERIOD;
                end else begin
                    seq_phase = PH_READ_BUSY;
                end
            end
            PH_WAIT_PERIOD: begin
                if (now - period_t0 >= {16'd0, cfg_period_us}) begin
                    period_t0 = now;
                    seq_phase = PH_CONV_NEXT;
                end
            end
            PH_FINISH: begin
                r.cycle_done = 1'b1;
                seq_phase    = PH_IDLE;
            end
            default: seq_phase = PH_IDLE;
        endcase
        us_count = now + 32'd1;
        return r;
    endfunction

    function automatic void check_field(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
        end
    endfunction

    // Track reset, register writes and both handshakes on the rising edge.
    // Retire the oldest owed word before queuing the one just accepted.
    always @(posedge i_clk) begin : scoreboard
        t_out_word want;
        if (!i_rst_n) begin
            cfg_cycle_us   = CYCLE_TIME_RST;
            cfg_ranging_us = RANGING_TIME_RST;
            cfg_window_us  = WINDOW_RST;
            cfg_period_us  = PERIOD_RST;
            cfg_enabled    = 4'd0;
            cfg_camera     = 1'b0;
            us_count       = '0;
            for (int k = 0; k < SENSORS; k++) last_fire[k] = '0;
            seq_phase      = PH_IDLE;
            window_t0      = '0;
            period_t0      = '0;
            rounds_done    = '0;
            cursor         = '0;
            firing         = '0;
            all_sensors    = 1'b0;
            pending_pins.delete();
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (pending_pins.size() == 0) begin
                    mismatch_count++;
                    $display("%0t: unexpected result word, expected none actual %h",
                             $time, o_out_word);
                end else begin
                    want = pending_pins.pop_front();
                    check_field("address_pins", want.address_pins, o_out_word.address_pins);
                    check_field("control_pins", want.control_pins, o_out_word.control_pins);
                    check_field("camera_trigger", want.camera_trigger,
                                o_out_word.camera_trigger);
                    check_field("active", want.active, o_out_word.active);
                    check_field("sample_valid", want.sample_valid, o_out_word.sample_valid);
                    check_field("sample_sensor", want.sample_sensor, o_out_word.sample_sensor);
                    check_field("sample_value", want.sample_value, o_out_word.sample_value);
                    check_field("sample_time", want.sample_time, o_out_word.sample_time);
                    check_field("sample_index", want.sample_index, o_out_word.sample_index);
                    check_field("cycle_done", want.cycle_done, o_out_word.cycle_done);
                    check_field("start_rejected", want.start_rejected,
                                o_out_word.start_rejected);
                end
            end
            if (i_in_valid && o_in_ready) pending_pins.push_back(pins_for_tick(i_in_word));
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CYCLE_TIME:   cfg_cycle_us   = i_cfg_data;
                    CFG_RANGING_TIME: cfg_ranging_us = i_cfg_data;
                    CFG_WINDOW:       cfg_window_us  = i_cfg_data;
                    CFG_PERIOD:       cfg_period_us  = i_cfg_data[15:0];
                    CFG_ENABLE_MASK:  cfg_enabled    = i_cfg_data[3:0];
                    CFG_CAMERA:       cfg_camera     = i_cfg_data[0];
                    default: ;
                endcase
            end
        end
    end

    // Receiver: hold a stall mode for a random stretch, then pick another.
    // Mode zero never stalls; the others stall lightly, heavily or periodically.
    always @(negedge i_clk) begin : stall_pattern
        int mode;
        int left;
        if (left == 0) begin
            mode = $urandom_range(0, 3);
            left = $urandom_range(32, 256);
        end else begin
            left--;
        end
        case (mode)
            0:       i_out_ready <= 1'b1;
            1:       i_out_ready <= ($urandom_range(0, 3) != 0);
            2:       i_out_ready <= ($urandom_range(0, 3) == 0);
            default: i_out_ready <= (left % 3 != 0);
        endcase
    end

    // Drop the run when neither side moves a word for too long
    always @(posedge i_clk) begin : watchdog
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("ranging_sampling_sequencer_unit_tb failed");
                $finish;
            end
        end
    end

    // Random tick: start often when idle, rarely otherwise (those get rejected);
    // busy mostly low, with occasional long stuck-high runs.
    function automatic t_in_word random_tick(input bit may_start);
        t_in_word w;
        w.fire_sensor = 2'($urandom_range(0, 3));
        w.sample_all  = 1'($urandom_range(0, 1));
        w.data_bus    = 8'($urandom_range(0, 255));
        if (seq_phase == PH_IDLE)
            w.start_request = may_start && ($urandom_range(0, 2) != 0);
        else
            w.start_request = ($urandom_range(0, 15) == 0);
        if (busy_hold > 0) begin
            busy_hold--;
            w.busy_pin = 1'b1;
        end else if ($urandom_range(0, 39) == 0) begin
            busy_hold  = $urandom_range(4, 30);
            w.busy_pin = 1'b1;
        end else begin
            w.busy_pin = ($urandom_range(0, 3) == 0);
        end
        return w;
    endfunction

    // Send one word; called and returns at a falling edge. Insert a gap only
    // between bursts so valid never drops and rises in the same step.
    task automatic send_word(input t_in_word w);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        burst_left--;
        @(negedge i_clk);
    endtask

    // Hold the sender until every owed word has come back
    task automatic pause_until_drained();
        i_in_valid <= 1'b0;
        while (pending_pins.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Feed random ticks without new starts until the sequencer is idle again
    task automatic run_until_idle();
        while (seq_phase != PH_IDLE) send_word(random_tick(1'b0));
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
    endtask

    // Rewrite the whole register file once the unit is drained
    task automatic apply_setting(input logic [23:0] cycle_us, input logic [23:0] ranging_us,
                                 input logic [23:0] window_us, input logic [15:0] period_us,
                                 input logic [3:0] enabled, input logic camera);
        pause_until_drained();
        @(negedge i_clk);
        put_reg(CFG_CYCLE_TIME, cycle_us);
        put_reg(CFG_RANGING_TIME, ranging_us);
        put_reg(CFG_WINDOW, window_us);
        put_reg(CFG_PERIOD, {8'd0, period_us});
        put_reg(CFG_ENABLE_MASK, {20'd0, enabled});
        put_reg(CFG_CAMERA, {23'd0, camera});
        i_cfg_we <= 1'b0;
    endtask

    // Out of reset every sensor is disabled: each start must bounce
    task automatic test_rejected_starts();
        t_in_word w;
        for (int s = 0; s < 4; s++) begin
            w.start_request = 1'b1;
            w.fire_sensor   = 2'(s);
            w.sample_all    = s[0];
            w.busy_pin      = s[1];
            w.data_bus      = s[0] ? 8'hFF : 8'h00;
            send_word(w);
        end
        w.start_request = 1'b0;
        send_word(w);
        pause_until_drained();
    endtask

    // Zero window: all-sensors conversion rounds, camera pulse, then finish with
    // no reads; a second start while active must be rejected
    task automatic test_empty_window();
        t_in_word w;
        apply_setting(24'd0, 24'd0, 24'd0, 16'd1, 4'hF, 1'b1);
        w.start_request = 1'b1;
        w.fire_sensor   = 2'd3;
        w.sample_all    = 1'b1;
        w.busy_pin      = 1'b1;
        w.data_bus      = 8'hA5;
        send_word(w);
        w.fire_sensor = 2'd0;
        w.busy_pin    = 1'b0;
        w.data_bus    = 8'h5A;
        send_word(w);
        run_until_idle();
    endtask

    // Partial mask: a disabled sensor bounces, an enabled one runs a single read
    task automatic test_single_read();
        t_in_word w;
        apply_setting(24'd3, 24'd2, 24'd1, 16'd0, 4'b0100, 1'b0);
        w.start_request = 1'b1;
        w.fire_sensor   = 2'd1;
        w.sample_all    = 1'b0;
        w.busy_pin      = 1'b0;
        w.data_bus      = 8'h3C;
        send_word(w);
        w.fire_sensor = 2'd2;
        send_word(w);
        run_until_idle();
    endtask

    // Random settings with short timings; each phase ends with the sequencer idle
    task automatic test_random_cycles();
        int sent;
        int n;
        int phase_no;
        sent     = 0;
        phase_no = 0;
        while (sent < RANDOM_TICKS) begin
            apply_setting(24'($urandom_range(0, 40)), 24'($urandom_range(0, 12)),
                          24'(($urandom_range(0, 3) == 0) ? $urandom_range(40, 160)
                                                           : $urandom_range(0, 40)),
                          16'($urandom_range(0, 8)), 4'($urandom_range(0, 15)),
                          1'($urandom_range(0, 1)));
            n = $urandom_range(20, 80);
            for (int i = 0; i < n; i++) begin
                send_word(random_tick(1'b1));
                sent++;
                // Drain once mid-phase, with a cycle likely in flight
                if (phase_no == 1 && i == n / 2) pause_until_drained();
            end
            run_until_idle();
            phase_no++;
        end
    endtask

    // Longest sample period: one all-sensors round, hold in the period wait,
    // then shorten the period so the window closes
    task automatic test_long_period();
        t_in_word w;
        apply_setting(24'd0, 24'd1, 24'd1, 16'hFFFF, 4'b1000, 1'b1);
        w.start_request = 1'b1;
        w.fire_sensor   = 2'd3;
        w.sample_all    = 1'b1;
        w.busy_pin      = 1'b0;
        w.data_bus      = 8'h7E;
        send_word(w);
        while (seq_phase != PH_WAIT_PERIOD) send_word(random_tick(1'b0));
        for (int i = 0; i < 16; i++) send_word(random_tick(1'b0));
        apply_setting(24'd0, 24'd1, 24'd1, 16'd0, 4'b1000, 1'b1);
        run_until_idle();
    endtask

    // Largest cycle and ranging times with all sensors off: only rejections
    task automatic test_idle_extremes();
        apply_setting(24'hFFFFFF, 24'hFFFFFF, 24'd0, 16'd0, 4'h0, 1'b0);
        for (int i = 0; i < 8; i++) send_word(random_tick(1'b1));
        pause_until_drained();
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_word   = '0;
        i_out_ready = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = '0;
        i_cfg_data  = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_rejected_starts();
        test_empty_window();
        test_single_read();
        test_random_cycles();
        test_long_period();
        test_idle_extremes();

        // Let any stray result word show up before judging
        repeat (4) @(posedge i_clk);
        if (pending_pins.size() != 0) begin
            mismatch_count++;
            $display("%0t: expected %0d more result words, actual 0", $time,
                     pending_pins.size());
        end
        if (mismatch_count == 0)
            $display("ranging_sampling_sequencer_unit_tb passed");
        else
            $display("ranging_sampling_sequencer_unit_tb failed");
        $finish;
    end

endmodule
